/* sv/base64_stream_codec_top_assert.svh */
// Assertion helpers shared by the codec RTL.
`ifndef BASE64_STREAM_CODEC_TOP_ASSERT_SVH
`define BASE64_STREAM_CODEC_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define B64C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64c_pkg;

  localparam int unsigned NumOut = 4;
  localparam logic [7:0]  PadChar = 8'h3D;  // '='

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // Codec state carried between beats.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  cnt;
    logic        halted;
  } state_t;

  // Results caused by one input beat.
  typedef struct packed {
    logic [NumOut-1:0][7:0] bytes;
    logic [2:0]             n;
    logic                   dv;
    logic                   stop;
    logic                   last;
  } group_t;

  // 6-bit value to alphabet character.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h00;
    if (v < 6'd26)      c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62) c = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = 8'h2B;
    else                c = 8'h2F;
    return c;
  endfunction

  // Character to {valid, 6-bit value}.
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B)               r = {1'b1, 6'd62};
    else if (c == 8'h2F)               r = {1'b1, 6'd63};
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/b64c_if.sv */
// ----------------------------------------------------------------------------
// b64c_in_if / b64c_out_if
// Valid/ready channels of the codec: input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       data_valid;
  logic       out_last;
  logic       stopped_early;

  modport source (output valid, output out_byte, output data_valid, output out_last,
                  output stopped_early, input ready);
  modport sink   (input valid, input out_byte, input data_valid, input out_last,
                  input stopped_early, output ready);
endinterface

`default_nettype wire

/* sv/b64c_core.sv */
// ----------------------------------------------------------------------------
// b64c_core
// Next state and result group for one input beat, encode or decode.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_core (
  input  wire logic            mode_i,
  input  wire b64c_pkg::state_t st_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  output b64c_pkg::state_t     st_o,
  output b64c_pkg::group_t     grp_o
);

  logic [1:0]  enc_cnt;
  logic [23:0] enc_bits;
  logic [23:0] enc_ins;
  logic [2:0]  enc_new_cnt;
  logic [6:0]  sx;
  logic [23:0] dec_ins;
  logic [23:0] dec_bits;
  logic        full;

  always_comb begin
    st_o  = st_i;
    grp_o = '0;
    enc_cnt = (st_i.cnt == 2'd3) ? 2'd0 : st_i.cnt;
    enc_bits = '0;
    enc_ins = '0;
    enc_new_cnt = {1'b0, enc_cnt} + 3'd1;
    sx = b64c_pkg::char_to_sextet(byte_i);
    dec_ins = '0;
    dec_bits = st_i.bits;
    full = 1'b0;

    if (mode_i == b64c_pkg::ModeEncode) begin
      // drop a three-item group left over from decode
      case (enc_cnt)
        2'd0:    enc_ins = {byte_i, 16'h0000};
        2'd1:    enc_ins = {8'h00, byte_i, 8'h00};
        2'd2:    enc_ins = {16'h0000, byte_i};
        default: enc_ins = '0;
      endcase
      enc_bits = ((st_i.cnt == 2'd3) ? 24'h000000 : st_i.bits) | enc_ins;
      st_o.bits = enc_bits;
      st_o.cnt  = enc_new_cnt[1:0];
      grp_o.bytes[0] = b64c_pkg::sextet_to_char(enc_bits[23:18]);
      grp_o.bytes[1] = b64c_pkg::sextet_to_char(enc_bits[17:12]);
      grp_o.bytes[2] = b64c_pkg::sextet_to_char(enc_bits[11:6]);
      grp_o.bytes[3] = b64c_pkg::sextet_to_char(enc_bits[5:0]);
      grp_o.dv = 1'b1;
      if (enc_new_cnt == 3'd3) begin
        grp_o.n   = 3'd4;
        st_o.bits = '0;
        st_o.cnt  = 2'd0;
      end else if (last_i) begin
        grp_o.n = 3'd4;
        grp_o.bytes[3] = b64c_pkg::PadChar;
        if (enc_new_cnt != 3'd2) grp_o.bytes[2] = b64c_pkg::PadChar;
      end
    end else begin
      if (!st_i.halted) begin
        if (!sx[6]) begin
          st_o.halted = 1'b1;
        end else begin
          case (st_i.cnt)
            2'd0:    dec_ins = {sx[5:0], 18'h00000};
            2'd1:    dec_ins = {6'h00, sx[5:0], 12'h000};
            2'd2:    dec_ins = {12'h000, sx[5:0], 6'h00};
            default: dec_ins = {18'h00000, sx[5:0]};
          endcase
          dec_bits  = st_i.bits | dec_ins;
          st_o.bits = dec_bits;
          if (st_i.cnt == 2'd3) begin
            full      = 1'b1;
            st_o.bits = '0;
            st_o.cnt  = 2'd0;
          end else begin
            st_o.cnt = st_i.cnt + 2'd1;
          end
        end
      end
      grp_o.bytes[0] = dec_bits[23:16];
      grp_o.bytes[1] = dec_bits[15:8];
      grp_o.bytes[2] = dec_bits[7:0];
      grp_o.dv = 1'b1;
      if (full) begin
        grp_o.n = 3'd3;
      end else if (last_i) begin
        grp_o.stop = st_o.halted;
        case (st_o.cnt)
          2'd2: grp_o.n = 3'd1;
          2'd3: grp_o.n = 3'd2;
          default: begin
            // nothing to flush: close with an empty marker
            grp_o.n     = 3'd1;
            grp_o.dv    = 1'b0;
            grp_o.bytes = '0;
          end
        endcase
      end
    end

    grp_o.last = last_i;
    if (last_i) st_o = '0;
  end

endmodule

`default_nettype wire

/* sv/b64c_out_buf.sv */
// ----------------------------------------------------------------------------
// b64c_out_buf
// Result register holding up to four beats of one group, sent one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_codec_top_assert.svh"

module b64c_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire b64c_pkg::group_t grp_i,
  output logic                  ready_o,
  b64c_out_if.source            out_o
);

  logic [b64c_pkg::NumOut-1:0][7:0] bytes_q;
  logic [2:0] rem_q, rem_d;
  logic [1:0] idx_q, idx_d;
  logic       dv_q;
  logic       stop_q;
  logic       last_q;
  logic       fire;

  assign fire    = out_o.valid && out_o.ready;
  assign ready_o = (rem_q == 3'd0) || (rem_q == 3'd1 && fire);

  assign out_o.valid         = (rem_q != 3'd0);
  assign out_o.out_byte      = bytes_q[idx_q];
  assign out_o.data_valid    = dv_q;
  assign out_o.stopped_early = stop_q;
  assign out_o.out_last      = last_q && (rem_q == 3'd1);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (fire) begin
      rem_d = rem_q - 3'd1;
      idx_d = idx_q + 2'd1;
    end
    if (load_i) begin
      rem_d = grp_i.n;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      idx_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= grp_i.bytes;
      dv_q    <= grp_i.dv;
      stop_q  <= grp_i.stop;
      last_q  <= grp_i.last;
    end
  end

  `B64C_ASSERT(a_fill_bound, ({1'b0, rem_q} + {2'b00, idx_q}) <= 4'd4, "beat index past group")
  `B64C_ASSERT(a_load_empty, !load_i || rem_q == 3'd0 || (rem_q == 3'd1 && fire), "load over pending beats")
  `B64C_ASSERT(a_marker_single, rem_q == 3'd0 || dv_q || (rem_q == 3'd1 && idx_q == 2'd0), "marker not alone")
  `B64C_ASSERT_NEXT(a_load_count, load_i, rem_q == $past(grp_i.n), "group count not taken")

endmodule

`default_nettype wire

/* sv/base64_stream_codec_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Streaming base64 codec (standard alphabet, '=' padding) with a mode register.
// ----------------------------------------------------------------------------
// Encode (mode 0) packs three bytes into four characters and pads a short final
// group with '='; decode (mode 1) turns four characters into three bytes (or a
// short final group into one or two) and stops for the rest of a message at the
// first '=' or non-alphabet character. When an input beat is taken, the group
// state updates at once and the beat's results (up to four) load the result
// register, which sends one beat per cycle while the sink is ready. A new input
// is taken in any cycle where that register is empty or sending its final beat,
// so inputs that give no result go at one per cycle while it is empty. Write mode
// only while the codec is idle.
`default_nettype none

module base64_stream_codec_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  b64c_in_if.sink    in_i,
  b64c_out_if.source out_o
);

  logic             mode_q;
  b64c_pkg::state_t st_q, st_d;
  b64c_pkg::group_t grp;
  logic             buf_ready;
  logic             accept;
  logic             load;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;
  assign load       = accept && (grp.n != 3'd0);

  b64c_core u_core (
    .mode_i (mode_q),
    .st_i   (st_q),
    .byte_i (in_i.in_byte),
    .last_i (in_i.in_last),
    .st_o   (st_d),
    .grp_o  (grp)
  );

  b64c_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .grp_i   (grp),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= b64c_pkg::ModeEncode;
      st_q   <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (accept)   st_q   <= st_d;
    end
  end

endmodule

`default_nettype wire
